// ===== rtl/cubic_hermite_audio_resampler_core_assert.svh =====
// Assertion macros for the resampler core.
// Used by the top level only.
`ifndef CUBIC_HERMITE_AUDIO_RESAMPLER_CORE_ASSERT_SVH
`define CUBIC_HERMITE_AUDIO_RESAMPLER_CORE_ASSERT_SVH
// implication checked on every edge outside reset
`define CHR_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define CHR_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/chr_pkg.sv =====
// Package for the resampler: constants, controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps
package chr_pkg;
  localparam int unsigned PhW = 29;
  localparam int unsigned GainW = 16;
  localparam int unsigned DefChannels = 2;
  localparam int unsigned DefSampleBits = 24;
  localparam int unsigned OutW = 24;
  localparam int unsigned MaxOut = 64;
  localparam logic [PhW-1:0] PhOne = 29'd16777216;
  localparam logic [PhW-1:0] PhHalf = 29'd8388608;
  localparam logic [PhW-1:0] PhMax = 29'h1FFFFFFF;
  localparam logic [1:0] ModeHermite = 2'd0;
  localparam logic [1:0] ModeLinear = 2'd1;
  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegStep = 2'd1;
  localparam logic [1:0] RegGain = 2'd2;
  localparam logic [1:0] RegPrec = 2'd3;

  typedef struct packed {
    logic shift_in;  // load new frame into history
    logic start;     // begin computing one output at current phase
  } chr_cmd_t;

  typedef struct packed {
    logic done;      // datapath result registered
  } chr_sts_t;
endpackage

// ===== rtl/chr_datapath.sv =====
// Datapath: sample history, multi-cycle interpolation pipeline, gain and saturation.
// Depends on chr_pkg.
`timescale 1ns / 1ps
module chr_datapath import chr_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chr_cmd_t              cmd,
  output chr_sts_t              sts,
  input  logic [1:0]            mode,
  input  logic [GainW-1:0]      gain,
  input  logic [4:0]            prec,
  input  logic [PhW-1:0]        mu_in,
  input  logic signed [OutW-1:0] left_in,
  input  logic signed [OutW-1:0] right_in,
  output logic signed [OutW-1:0] left_res,
  output logic signed [OutW-1:0] right_res
);
  // history: 4 per channel, index 0 oldest
  logic signed [SAMPLE_BITS-1:0] hist [2][4];
  logic [2:0] stage;   // one-hot-ish pipeline position
  logic [24:0] mu;
  logic [24:0] mu2, mu3;
  logic signed [27:0] a0, a1, a2, a3;
  // Q8 value; Hermite overshoot needs headroom above 32 bits
  logic signed [33:0] val [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++)
        for (int k = 0; k < 4; k++) hist[c][k] <= '0;
    end else if (cmd.shift_in) begin
      for (int k = 0; k < 3; k++) begin
        hist[0][k] <= hist[0][k+1];
        hist[1][k] <= hist[1][k+1];
      end
      hist[0][3] <= left_in[SAMPLE_BITS-1:0];
      hist[1][3] <= (CHANNELS > 1) ? right_in[SAMPLE_BITS-1:0] : '0;
    end
  end

  function automatic logic signed [63:0] herm(input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b, input logic signed [SAMPLE_BITS-1:0] c,
      input logic signed [SAMPLE_BITS-1:0] d, input logic signed [27:0] k0,
      input logic signed [27:0] k1, input logic signed [27:0] k2,
      input logic signed [27:0] k3);
    logic signed [25:0] tb, tc, ca, db;
    begin
      tb = 26'(b) * 26'sd2;
      tc = 26'(c) * 26'sd2;
      ca = 26'(c) - 26'(a);
      db = 26'(d) - 26'(b);
      herm = 64'(k0) * 64'(tb) + 64'(k1) * 64'(ca) + 64'(k2) * 64'(db) + 64'(k3) * 64'(tc);
    end
  endfunction

  function automatic logic signed [31:0] fin(input logic signed [50:0] g,
      input logic [4:0] p);
    logic signed [50:0] t;
    logic [4:0] pc;
    logic signed [31:0] hi, lo;
    begin
      t = (g >= 0) ? (g >>> 22) : -((-g) >>> 22);
      pc = (p < 5'd2) ? 5'd2 : ((p > 5'd24) ? 5'd24 : p);
      hi = (32'sd1 <<< (pc - 5'd1)) - 32'sd1;
      lo = -(32'sd1 <<< (pc - 5'd1));
      if (t > 51'(hi)) fin = hi;
      else if (t < 51'(lo)) fin = lo;
      else fin = 32'(t);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[1:0], cmd.start};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mu <= mu_in[24:0];
      mu2 <= 25'((50'(mu_in[24:0]) * 50'(mu_in[24:0])) >> 24);
    end
    if (stage[0]) mu3 <= 25'((50'(mu2) * 50'(mu)) >> 24);
    if (stage[1]) begin
      for (int c = 0; c < 2; c++) begin
        if (mode == ModeHermite) begin
          val[c] <= 34'(herm(hist[c][0], hist[c][1], hist[c][2], hist[c][3],
                     a0, a1, a2, a3) >>> 17);
        end else if (mode == ModeLinear) begin
          val[c] <= 34'((64'(hist[c][2]) * 64'sd16777216 +
                     (64'(hist[c][3]) - 64'(hist[c][2])) * 64'($signed({1'b0, mu})))
                     >>> 16);
        end else begin
          val[c] <= (mu < 25'(PhHalf)) ? 34'(hist[c][2]) <<< 8 : 34'(hist[c][3]) <<< 8;
        end
      end
    end
    if (stage[2]) begin
      left_res <= OutW'(fin(51'(val[0]) * 51'($signed({1'b0, gain})), prec));
      right_res <= (CHANNELS > 1) ?
                   OutW'(fin(51'(val[1]) * 51'($signed({1'b0, gain})), prec)) : '0;
    end
  end

  always_comb begin
    a0 = 28'sd2 * 28'(mu3) - 28'sd3 * 28'(mu2) + 28'sd16777216;
    a1 = 28'(mu3) - 28'sd2 * 28'(mu2) + 28'(mu);
    a2 = 28'(mu3) - 28'(mu2);
    a3 = -28'sd2 * 28'(mu3) + 28'sd3 * 28'(mu2);
  end

  // done: registered by the same edge that registers the gain stage result
  logic done_q;
  always_ff @(posedge clk) begin
    if (rst) done_q <= 1'b0;
    else done_q <= stage[2];
  end
  assign sts.done = done_q;
endmodule

// ===== rtl/chr_ctrl.sv =====
// Controller: phase accumulator, output count and handshake sequencing.
// Depends on chr_pkg.
`timescale 1ns / 1ps
module chr_ctrl import chr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  output logic           in_rdy,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           out_last,
  input  logic           step_wr,
  input  logic [PhW-1:0] step,
  output logic [PhW-1:0] phase,
  output chr_cmd_t       cmd,
  input  chr_sts_t       sts
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SCalc = 2'd1;
  localparam logic [1:0] SOut = 2'd2;
  localparam logic [1:0] SStart = 2'd3;

  logic [1:0] state;
  logic [6:0] count;
  logic [29:0] psum;
  logic run;
  logic [PhW-1:0] phase_next;

  assign in_rdy = (state == SIdle);
  assign psum = 30'(phase) + 30'(step);
  assign run = (phase <= PhOne) && (count < 7'(MaxOut));
  assign cmd.shift_in = in_fire;
  // only start the datapath when another output is really due
  assign cmd.start = (state == SStart) && run;

  always_comb begin
    phase_next = phase;
    if (state == SStart && !run) begin
      phase_next = (phase > PhOne) ? phase - PhOne : '0;
    end else if (state == SCalc && sts.done) begin
      phase_next = (psum > 30'(PhMax)) ? PhMax : psum[PhW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      phase <= '0;
      count <= '0;
      out_valid <= 1'b0;
      out_last <= 1'b0;
    end else begin
      phase <= step_wr ? '0 : phase_next;
      unique case (state)
        SIdle: begin
          count <= '0;
          if (in_fire) state <= SStart;
        end
        SStart: begin
          if (run) begin
            state <= SCalc;
          end else begin
            state <= SIdle;
          end
        end
        SCalc: begin
          if (sts.done) begin
            count <= count + 7'd1;
            out_valid <= 1'b1;
            out_last <= ((psum > 30'(PhOne)) || (count == 7'(MaxOut - 1)));
            state <= SOut;
          end
        end
        SOut: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= SStart;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule

// ===== rtl/cubic_hermite_audio_resampler_core.sv =====
// Top level of the stereo resampler: config registers, controller, datapath.
// Depends on chr_pkg, chr_ctrl, chr_datapath and the assertion header.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready, left_in, right_in): one stereo frame per
//   transaction. in_ready is high only while the block is idle.
//   Output channel (out_valid/out_ready, left_out, right_out, last): zero to
//   64 transactions per input frame; last marks the final one.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 mode, 1 step ratio (clears phase), 2 gain, 3 precision.
// Timing: each output frame passes from the phase check through the datapath
//   (squares, cube, interpolation, gain) to the output register, then holds
//   there for as long as the receiver stalls. No new input frame is taken
//   until every output of the current one has been delivered.
// Reset clears phase, history and registers to their defaults.
// While out_ready is low the result holds in the output register and no new
// frame is started.
module cubic_hermite_audio_resampler_core import chr_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [OutW-1:0] left_in,
  input  logic signed [OutW-1:0] right_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [OutW-1:0] left_out,
  output logic signed [OutW-1:0] right_out,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);
  logic [1:0] mode;
  logic [PhW-1:0] step;
  logic [GainW-1:0] gain;
  logic [4:0] prec;
  logic [PhW-1:0] phase;
  logic in_fire, cfg_fire;
  chr_cmd_t cmd;
  chr_sts_t sts;

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid & cfg_ready;
  assign in_fire = in_valid & in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeHermite;
      step <= PhOne;
      gain <= 16'd16384;
      prec <= 5'd16;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        RegMode: mode <= cfg_data[1:0];
        RegStep: step <= cfg_data[PhW-1:0];
        RegGain: gain <= cfg_data[GainW-1:0];
        RegPrec: prec <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  chr_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_rdy(in_ready), .out_ready, .out_valid,
    .out_last(last), .step_wr(cfg_fire && cfg_index == RegStep), .step,
    .phase, .cmd, .sts
  );

  chr_datapath #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .mode, .gain, .prec, .mu_in(phase),
    .left_in, .right_in, .left_res(left_out), .right_res(right_out)
  );

`include "cubic_hermite_audio_resampler_core_assert.svh"
  // no new frame while a result is pending
  `CHR_ASSERT_IMP(a_no_in_during_out, out_valid, !in_ready)
  // computation is only started with phase within one
  `CHR_ASSERT_IMP(a_start_phase, cmd.start, phase <= PhOne)
  // a delivered last result returns the block toward idle
  `CHR_ASSERT_NXT(a_last_idle, out_valid && out_ready && last, !out_valid)
endmodule
